// ===== design/rppb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppb_pkg: shared types, constants and table builder
// Payload structs, the queue entry between the front and back parts, the
// configuration register indexes and the quarter-wave sine generator used to
// fill the gain table at elaboration.
// ----------------------------------------------------------------------------
package rppb_pkg;

  // Default sizes
  localparam int PHASE_BITS_DEF = 32;
  localparam int TABLE_BITS_DEF = 10;
  localparam int PHASE_MAX_BITS = 32;

  // Command queue depth between the front and back parts
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_ENABLE = 1'b0,
    CFG_STEP   = 1'b1
  } cfg_idx_t;

  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Input beat
  typedef struct packed {
    logic signed [7:0] feedback;
    logic              random_bit;
  } in_t;

  // Result beat
  typedef struct packed {
    logic signed [15:0] cos_out;
    logic signed [15:0] sin_out;
    logic               updated;
  } out_t;

  // Classified item: phase change to apply, and whether it counts
  typedef struct packed {
    logic                      updated;
    logic [PHASE_MAX_BITS-1:0] delta;
  } cmd_t;

  // sin(pi/2 * k / 2^qlog) in Q1.15, Taylor series in Q2.30 (Horner form)
  function automatic logic [15:0] quarter_sine(input logic [63:0] k, input int qlog);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x  = (HALF_PI_Q30 * k) >> qlog;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd272);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd210);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    r  = (s + (64'd1 << 14)) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

endpackage

// ===== design/rppb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppb_front: feedback classifier
// Accepts input beats, decides whether each one moves the phase and works out
// the phase change (new perturbation minus, on bad feedback, the last one).
// ----------------------------------------------------------------------------
module rppb_front #(
  parameter int PHASE_BITS = rppb_pkg::PHASE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rppb_pkg::in_t        in_data,
  input  logic                 enable,
  input  logic [31:0]          step_phase,
  output logic                 push_valid,
  input  logic                 push_ready,
  output rppb_pkg::cmd_t       push_cmd
);

  logic signed [7:0]     last_fb_r;
  logic signed [7:0]     last_fb_nxt;
  logic [PHASE_BITS-1:0] prev_pert_r;
  logic [PHASE_BITS-1:0] prev_pert_nxt;
  logic [PHASE_BITS-1:0] step;
  logic [PHASE_BITS-1:0] pert;
  logic [PHASE_BITS-1:0] delta;
  logic                  hit;
  logic                  accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // Classify the beat and form the phase change
  always_comb begin
    step  = step_phase[31 -: PHASE_BITS];
    hit   = enable && (in_data.feedback != 8'sd0) && (in_data.feedback != last_fb_r);
    pert  = in_data.random_bit ? step : (PHASE_BITS'(0) - step);
    delta = in_data.feedback[7] ? (pert - prev_pert_r) : pert;
    push_cmd.updated = hit;
    push_cmd.delta   = hit ? rppb_pkg::PHASE_MAX_BITS'(delta) : '0;
    last_fb_nxt   = last_fb_r;
    prev_pert_nxt = prev_pert_r;
    if (accept && hit) begin
      last_fb_nxt   = in_data.feedback;
      prev_pert_nxt = pert;
    end
  end

  // Hold the last accepted feedback and perturbation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_fb_r   <= '0;
      prev_pert_r <= '0;
    end else begin
      last_fb_r   <= last_fb_nxt;
      prev_pert_r <= prev_pert_nxt;
    end
  end

endmodule

// ===== design/rppb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppb_queue: command queue
// Short first-in first-out buffer between the classifier and the phase
// engine; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module rppb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rppb_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rppb_pkg::cmd_t pop_cmd
);

  localparam int CNT_W = $clog2(rppb_pkg::QUEUE_DEPTH + 1);

  rppb_pkg::cmd_t                 entry_r [rppb_pkg::QUEUE_DEPTH];
  logic [rppb_pkg::QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [rppb_pkg::QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0]               count_r;
  logic [CNT_W-1:0]               count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = (count_r != CNT_W'(rppb_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + rppb_pkg::QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + rppb_pkg::QUEUE_PTR_W'(1);
      end
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/rppb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppb_back: phase engine
// Applies queued phase changes to the accumulator, looks up the quarter-wave
// sine table, unfolds the quadrant and holds the current gain.
// ----------------------------------------------------------------------------
module rppb_back #(
  parameter int PHASE_BITS = rppb_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS = rppb_pkg::TABLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  rppb_pkg::cmd_t pop_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output rppb_pkg::out_t out_data
);

  localparam int QLOG    = TABLE_BITS - 2;
  localparam int QUARTER = 1 << QLOG;

  logic [15:0]           sine_tab [QUARTER + 1];
  logic [PHASE_BITS-1:0] phase_acc_r;
  logic [PHASE_BITS-1:0] phase_sum;
  logic [TABLE_BITS-1:0] tab_idx;
  logic [QLOG-1:0]       rem;
  logic [QLOG:0]         idx_a;
  logic [QLOG:0]         idx_b;

  logic                  s1_valid_r;
  logic                  s1_upd_r;
  logic [1:0]            s1_quad_r;
  logic signed [15:0]    s1_a_r;
  logic signed [15:0]    s1_b_r;
  logic                  s1_en;

  logic signed [15:0]    gain_cos_r;
  logic signed [15:0]    gain_sin_r;
  logic signed [15:0]    cos_new;
  logic signed [15:0]    sin_new;
  logic                  out_valid_r;
  rppb_pkg::out_t        out_data_r;
  rppb_pkg::out_t        out_nxt;
  logic                  out_en;

  // Quarter-wave sine table, built at elaboration
  for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
    assign sine_tab[k] = rppb_pkg::quarter_sine(64'(k), QLOG);
  end

  // Stage enables
  assign out_en    = !out_valid_r || out_ready;
  assign s1_en     = !s1_valid_r || out_en;
  assign pop_ready = s1_en;

  // Accumulate and index the table
  always_comb begin
    phase_sum = phase_acc_r + pop_cmd.delta[PHASE_BITS-1:0];
    tab_idx   = phase_sum[PHASE_BITS-1 -: TABLE_BITS];
    rem       = tab_idx[QLOG-1:0];
    idx_a     = {1'b0, rem};
    idx_b     = (QLOG+1)'(QUARTER) - {1'b0, rem};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      s1_valid_r  <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= pop_valid;
      if (pop_valid && pop_cmd.updated) begin
        phase_acc_r <= phase_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_upd_r  <= pop_valid && pop_cmd.updated;
      s1_quad_r <= tab_idx[TABLE_BITS-1 -: 2];
      s1_a_r    <= sine_tab[idx_a];
      s1_b_r    <= sine_tab[idx_b];
    end
  end

  // Unfold the quadrant and pick the new or held gain
  always_comb begin
    case (s1_quad_r)
      2'd0:    begin cos_new = s1_b_r;  sin_new = s1_a_r;  end
      2'd1:    begin cos_new = -s1_a_r; sin_new = s1_b_r;  end
      2'd2:    begin cos_new = -s1_b_r; sin_new = -s1_a_r; end
      default: begin cos_new = s1_a_r;  sin_new = -s1_b_r; end
    endcase
    out_nxt.updated = s1_upd_r;
    out_nxt.cos_out = s1_upd_r ? cos_new : gain_cos_r;
    out_nxt.sin_out = s1_upd_r ? sin_new : gain_sin_r;
  end

  // Hold the gain and the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      gain_cos_r  <= 16'sd32767;
      gain_sin_r  <= '0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        gain_cos_r <= out_nxt.cos_out;
        gain_sin_r <= out_nxt.sin_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/random_phase_perturb_beamformer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_phase_perturb_beamformer_top: one-bit-feedback phase adjuster
// Nudges a transmit phase by a configured step of random sign on each fresh
// feedback value and reports the resulting cos/sin gain in Q1.15.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/ready     feedback, random_bit
//   out_     output     out_valid/ready    cos_out, sin_out, updated
//   cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// One beat per cycle sustained while out_ready stays high; the classifier
// writes each taken beat into the queue, the s1 registers hold the phase add
// with table select, and the quadrant unfold goes into the output register.
// Reset is synchronous; it restores enable to 1, clears the step, phase,
// last feedback and perturbation, and sets the gain to (32767, 0).
// A stalled output fills the two-entry queue, after which in_ready drops.
// ----------------------------------------------------------------------------
module random_phase_perturb_beamformer_top #(
  parameter int PHASE_BITS = rppb_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS = rppb_pkg::TABLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rppb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rppb_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [31:0]    cfg_wdata
);

  logic           enable_r;
  logic [31:0]    step_r;
  logic           push_valid;
  logic           push_ready;
  rppb_pkg::cmd_t push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  rppb_pkg::cmd_t pop_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      step_r   <= '0;
    end else if (cfg_we) begin
      unique case (rppb_pkg::cfg_idx_t'(cfg_index))
        rppb_pkg::CFG_ENABLE: enable_r <= cfg_wdata[0];
        rppb_pkg::CFG_STEP:   step_r   <= cfg_wdata;
        default:              enable_r <= enable_r;
      endcase
    end
  end

  rppb_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .enable     (enable_r),
    .step_phase (step_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  rppb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  rppb_back #(
    .PHASE_BITS (PHASE_BITS),
    .TABLE_BITS (TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
